### hw/rtl/at_cmd_pkg.sv
// shared types and constants for the at command line matcher
// keyword text and lengths, result codes, queue sizing; no dependencies
`timescale 1ns / 1ps

package at_cmd_pkg;

	localparam int KW_COUNT       = 8;
	localparam int KW_MAX_LEN     = 8;
	localparam int MAX_LINE_CHARS = 63;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	typedef enum logic [3:0] {
		CMD_FWD     = 4'd0,
		CMD_LEFT    = 4'd1,
		CMD_RIGHT   = 4'd2,
		CMD_STOP    = 4'd3,
		CMD_MAN     = 4'd4,
		CMD_RST     = 4'd5,
		CMD_GET     = 4'd6,
		CMD_SAVE    = 4'd7,
		CMD_UNKNOWN = 4'd8
	} cmd_code_t;

	// one bit per keyword: line ended matching that keyword exactly
	typedef logic [KW_COUNT-1:0] kw_hit_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{8'h41, 8'h54, 8'h2B, 8'h46, 8'h57, 8'h44, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h2B, 8'h4C, 8'h45, 8'h46, 8'h54, 8'h00},
		'{8'h41, 8'h54, 8'h2B, 8'h52, 8'h49, 8'h47, 8'h48, 8'h54},
		'{8'h41, 8'h54, 8'h2B, 8'h53, 8'h54, 8'h4F, 8'h50, 8'h00},
		'{8'h41, 8'h54, 8'h2B, 8'h4D, 8'h41, 8'h4E, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h2B, 8'h52, 8'h53, 8'h54, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h2B, 8'h47, 8'h45, 8'h54, 8'h00, 8'h00},
		'{8'h41, 8'h54, 8'h2B, 8'h53, 8'h41, 8'h56, 8'h45, 8'h00}
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd7, 4'd8, 4'd7, 4'd6, 4'd6, 4'd6, 4'd7
	};

endpackage

### hw/rtl/at_cmd_front.sv
// front end: accepts bytes, tracks line length, overflow and keyword match flags
// pushes one hit vector per nonempty line without overflow; uses at_cmd_pkg
`timescale 1ns / 1ps

module at_cmd_front #(
	parameter int MAX_LINE_CHARS = at_cmd_pkg::MAX_LINE_CHARS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_vld,
	input  logic [7:0]            rx_char,
	output logic                  push,
	output at_cmd_pkg::kw_hit_t   push_hit
);

	localparam int LEN_W = $clog2(MAX_LINE_CHARS + 1);

	logic [LEN_W-1:0]    len_q;
	logic                ovf_q;
	at_cmd_pkg::kw_hit_t alive_q;
	at_cmd_pkg::kw_hit_t alive_nxt;
	at_cmd_pkg::kw_hit_t len_hit;
	logic                is_term;
	logic                has_room;

	assign is_term  = (rx_char == at_cmd_pkg::CHAR_CR) || (rx_char == at_cmd_pkg::CHAR_LF);
	assign has_room = len_q < LEN_W'(MAX_LINE_CHARS);

	always_comb begin
		for (int k = 0; k < at_cmd_pkg::KW_COUNT; k++) begin
			len_hit[k]   = len_q == LEN_W'(at_cmd_pkg::KW_LEN[k]);
			// position must lie inside the keyword and carry the same character
			alive_nxt[k] = alive_q[k] && (len_q < LEN_W'(at_cmd_pkg::KW_LEN[k]))
				&& (at_cmd_pkg::KW_TEXT[k][len_q[2:0]] == rx_char);
		end
	end

	assign push     = byte_vld && is_term && (len_q != '0) && !ovf_q;
	assign push_hit = alive_q & len_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			alive_q <= '1;
		end else if (byte_vld) begin
			if (is_term) begin
				len_q   <= '0;
				ovf_q   <= 1'b0;
				alive_q <= '1;
			end else if (has_room) begin
				len_q   <= len_q + LEN_W'(1);
				alive_q <= alive_nxt;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// overflow can only be set once the line is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_W'(MAX_LINE_CHARS)))
		else $error("overflow set below full line");

	// at most one keyword can match a line exactly
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> $onehot0(push_hit))
		else $error("several keywords hit");

endmodule

### hw/rtl/at_cmd_queue.sv
// two-entry queue of per-line hit vectors between front and back end
// uses at_cmd_pkg
`timescale 1ns / 1ps

module at_cmd_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  at_cmd_pkg::kw_hit_t       push_hit,
	input  logic                      pop,
	output at_cmd_pkg::kw_hit_t       pop_hit,
	output at_cmd_pkg::queue_status_t status
);

	localparam int PTR_W = $clog2(at_cmd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(at_cmd_pkg::QUEUE_DEPTH + 1);

	at_cmd_pkg::kw_hit_t entry_q [at_cmd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                do_push;
	logic                do_pop;

	assign status.full  = cnt_q == CNT_W'(at_cmd_pkg::QUEUE_DEPTH);
	assign status.empty = cnt_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_hit      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(at_cmd_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(at_cmd_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(at_cmd_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

### hw/rtl/at_cmd_back.sv
// back end: turns a hit vector into a command code and holds it in the output register
// uses at_cmd_pkg
`timescale 1ns / 1ps

module at_cmd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  at_cmd_pkg::kw_hit_t       pop_hit,
	input  at_cmd_pkg::queue_status_t status,
	output logic                      pop,
	input  logic                      out_rdy,
	output logic                      out_vld,
	output logic [3:0]                command_code
);

	at_cmd_pkg::cmd_code_t code;
	logic                  vld_q;
	logic [3:0]            code_q;

	always_comb begin
		code = at_cmd_pkg::CMD_UNKNOWN;
		for (int k = at_cmd_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (pop_hit[k]) begin
				code = at_cmd_pkg::cmd_code_t'(4'(k));
			end
		end
	end

	assign pop          = !status.empty && (!vld_q || out_rdy);
	assign out_vld      = vld_q;
	assign command_code = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || out_rdy) begin
			vld_q <= !status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q <= code;
		end
	end

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (code_q <= 4'(at_cmd_pkg::CMD_UNKNOWN)))
		else $error("command code out of range");

endmodule

### hw/rtl/at_command_line_matcher_top.sv
// top level of the at command line matcher: front end, queue, back end
// depends on at_cmd_pkg, at_cmd_front, at_cmd_queue, at_cmd_back
//
// channel   dir  tdata                        tuser  tlast
// s_axis    in   [7:0] rx_char                -      -
// m_axis    out  [3:0] command_code, [7:4] 0  -      -
//
// one byte per cycle while s_axis_tready is high; the match update for a byte is done
// in the cycle it is taken; a line end reaches m_axis via queue and output register
// s_axis_tready drops only while the two-entry queue is full
// reset clears line length, overflow, queue state and output valid; sets match flags
`timescale 1ns / 1ps

module at_command_line_matcher_top #(
	parameter int MAX_LINE_CHARS = at_cmd_pkg::MAX_LINE_CHARS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_char
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [3:0] command_code, [7:4] zero
);

	at_cmd_pkg::kw_hit_t       push_hit;
	at_cmd_pkg::kw_hit_t       pop_hit;
	at_cmd_pkg::queue_status_t status;
	logic                      push;
	logic                      pop;
	logic                      byte_vld;
	logic [3:0]                command_code;

	assign s_axis_tready = !status.full;
	assign byte_vld      = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata  = {4'b0000, command_code};

	at_cmd_front #(
		.MAX_LINE_CHARS(MAX_LINE_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (byte_vld),
		.rx_char  (s_axis_tdata),
		.push     (push),
		.push_hit (push_hit)
	);

	at_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_hit (push_hit),
		.pop      (pop),
		.pop_hit  (pop_hit),
		.status   (status)
	);

	at_cmd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_hit      (pop_hit),
		.status       (status),
		.pop          (pop),
		.out_rdy      (m_axis_tready),
		.out_vld      (m_axis_tvalid),
		.command_code (command_code)
	);

endmodule
